/* rtl/beam_break_event_capture_defines.svh */
// assertion macros for the beam break event capture block
`ifndef BEAM_BREAK_EVENT_CAPTURE_DEFINES_SVH
`define BEAM_BREAK_EVENT_CAPTURE_DEFINES_SVH
`ifndef SYNTHESIS
`define BBEC_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define BBEC_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`else
`define BBEC_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define BBEC_ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`endif
`endif

/* rtl/bbec_pkg.sv */
// shared types, constants and helper functions for beam break event capture
`timescale 1ns / 1ps
package bbec_pkg;

    localparam int BEAM_COUNT = 16;
    localparam int MASK_W     = 16;
    localparam int IDX_W      = 4;
    localparam int TS_W       = 64;
    localparam int CFG_W      = 32;
    localparam int CH_W       = 8;
    localparam int ADDR_W     = 3;
    localparam int S_DATA_W   = 80;
    localparam int M_DATA_W   = 160;

    typedef enum logic [0:0] {
        REG_QUIET_TIME = 1'b0,
        REG_MAX_EVENT  = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_EDGE = 1'b0,
        OP_POLL = 1'b1
    } op_t;

    typedef struct packed {
        logic [CFG_W-1:0] quiet_time;
        logic [CFG_W-1:0] max_event_time;
    } cfg_t;

    typedef struct packed {
        logic              valid_res;
        logic              timeout_flag;
        logic [TS_W-1:0]   start_time;
        logic [TS_W-1:0]   end_time;
        logic [MASK_W-1:0] seen_beams;
        logic [IDX_W-1:0]  low_beam;
        logic [IDX_W-1:0]  high_beam;
    } result_t;

    typedef struct packed {
        logic              event_open;
        logic [MASK_W-1:0] current_mask;
        logic [MASK_W-1:0] seen_mask;
    } status_t;

    function automatic logic [IDX_W-1:0] lowest_index(input logic [MASK_W-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = BEAM_COUNT - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [IDX_W-1:0] highest_index(input logic [MASK_W-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < BEAM_COUNT; i++) begin
            if (mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/bbec_cfg.sv */
// apb register file holding quiet time and maximum event time
`timescale 1ns / 1ps
module bbec_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbec_pkg::ADDR_W-1:0]  paddr,
    input  logic [bbec_pkg::CFG_W-1:0]   pwdata,
    output logic [bbec_pkg::CFG_W-1:0]   prdata,
    output logic                         pready,
    output bbec_pkg::cfg_t               cfg
);
    import bbec_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr_en;

    assign sel    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (sel)
                REG_QUIET_TIME: cfg_next.quiet_time     = pwdata;
                REG_MAX_EVENT:  cfg_next.max_event_time = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_QUIET_TIME: prdata = cfg_reg.quiet_time;
            REG_MAX_EVENT:  prdata = cfg_reg.max_event_time;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quiet_time     <= CFG_W'(20000);
            cfg_reg.max_event_time <= CFG_W'(200000);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/bbec_core.sv */
// input register, event state and single pass update logic
`timescale 1ns / 1ps
module bbec_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bbec_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic [bbec_pkg::CH_W-1:0]     in_channel,
    input  logic                          in_blocked,
    input  logic [bbec_pkg::TS_W-1:0]     in_timestamp,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bbec_pkg::result_t             res,
    output bbec_pkg::status_t             status
);
    import bbec_pkg::*;

    // input stage
    logic              in_valid_reg, in_valid_next;
    op_t               op_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              blk_reg;
    logic [TS_W-1:0]   ts_reg;

    // event state
    logic              open_reg, open_next;
    logic [MASK_W-1:0] cur_reg, cur_next;
    logic [MASK_W-1:0] seen_reg, seen_next;
    logic [TS_W-1:0]   start_reg, start_next;
    logic [TS_W-1:0]   last_reg, last_next;

    logic              advance;
    logic [TS_W:0]     since_start;
    logic [TS_W:0]     since_last;
    logic              past_limit;
    logic              quiet_ok;
    logic              ch_ok;
    logic [MASK_W-1:0] bit_mask;
    logic              close;
    logic              close_timeout;
    logic              res_ok;

    assign advance  = in_valid_reg & res_ready;
    assign in_ready = ~in_valid_reg | res_ready;

    assign since_start = {1'b0, ts_reg} - {1'b0, start_reg};
    assign since_last  = {1'b0, ts_reg} - {1'b0, last_reg};
    assign past_limit  = ~since_start[TS_W] &&
                         (since_start[TS_W-1:0] > {{(TS_W-CFG_W){1'b0}}, cfg.max_event_time});
    assign quiet_ok    = ~since_last[TS_W] &&
                         (since_last[TS_W-1:0] >= {{(TS_W-CFG_W){1'b0}}, cfg.quiet_time});
    assign ch_ok       = ch_reg < CH_W'(BEAM_COUNT);
    assign bit_mask    = MASK_W'(1) << ch_reg[IDX_W-1:0];

    always_comb begin
        open_next     = open_reg;
        cur_next      = cur_reg;
        seen_next     = seen_reg;
        start_next    = start_reg;
        last_next     = last_reg;
        close         = 1'b0;
        close_timeout = 1'b0;
        case (op_reg)
            OP_POLL: begin
                if (open_reg) begin
                    if (past_limit) begin
                        close         = 1'b1;
                        close_timeout = 1'b1;
                    end else if (cur_reg == '0 && quiet_ok) begin
                        close = 1'b1;
                    end
                end
                if (close) begin
                    open_next  = 1'b0;
                    cur_next   = '0;
                    seen_next  = '0;
                    start_next = '0;
                    last_next  = '0;
                end
            end
            OP_EDGE: begin
                if (ch_ok) begin
                    if (open_reg && past_limit) begin
                        // old event times out; a blocked edge starts a fresh one
                        close         = 1'b1;
                        close_timeout = 1'b1;
                        open_next     = blk_reg;
                        cur_next      = blk_reg ? bit_mask : '0;
                        seen_next     = blk_reg ? bit_mask : '0;
                        start_next    = blk_reg ? ts_reg : '0;
                        last_next     = blk_reg ? ts_reg : '0;
                    end else begin
                        if (blk_reg) begin
                            open_next = 1'b1;
                            if (!open_reg) begin
                                start_next = ts_reg;
                                cur_next   = bit_mask;
                                seen_next  = bit_mask;
                            end else begin
                                cur_next  = cur_reg | bit_mask;
                                seen_next = seen_reg | bit_mask;
                            end
                        end else if (open_reg) begin
                            cur_next = cur_reg & ~bit_mask;
                        end
                        last_next = ts_reg;
                    end
                end
            end
            default: close = 1'b0;
        endcase
    end

    // result fields come from the event as it stood before this item
    assign res_ok           = (seen_reg != '0) & ~since_start[TS_W];
    assign res_valid        = advance & close;
    assign res.valid_res    = res_ok;
    assign res.timeout_flag = close_timeout;
    assign res.start_time   = start_reg;
    assign res.end_time     = ts_reg;
    assign res.seen_beams   = seen_reg;
    assign res.low_beam     = res_ok ? lowest_index(seen_reg) : '0;
    assign res.high_beam    = res_ok ? highest_index(seen_reg) : '0;

    assign status.event_open   = open_reg;
    assign status.current_mask = cur_reg;
    assign status.seen_mask    = seen_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg  <= op_t'(in_op);
            ch_reg  <= in_channel;
            blk_reg <= in_blocked;
            ts_reg  <= in_timestamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            open_reg     <= 1'b0;
            cur_reg      <= '0;
            seen_reg     <= '0;
            start_reg    <= '0;
            last_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                open_reg  <= open_next;
                cur_reg   <= cur_next;
                seen_reg  <= seen_next;
                start_reg <= start_next;
                last_reg  <= last_next;
            end
        end
    end

endmodule

/* rtl/bbec_oreg.sv */
// output register holding one result until the receiver takes it
`timescale 1ns / 1ps
module bbec_oreg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    output logic                 res_ready,
    input  bbec_pkg::result_t    res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bbec_pkg::result_t    out_res
);
    import bbec_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    load;

    assign res_ready = ~out_valid_reg | out_ready;
    assign load      = res_valid & res_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/beam_break_event_capture.sv */
// beam break event capture: groups beam sensor edges into timed events
//
// input stream (s_): one transfer is either a beam edge (s_tuser = 0) with a
//   channel, blocked flag and microsecond timestamp, or a poll (s_tuser = 1)
//   that carries only the current time. channels at or above the beam count
//   are dropped without effect.
// result stream (m_): one transfer per closed event with valid flag, timeout
//   flag, start and end time, latched beam mask and lowest/highest beam index.
//   most input transfers produce no result.
// apb port: quiet_time at 0x0, max_event_time at 0x4; write only while idle.
// path: an accepted transfer is registered in the input register and evaluated
//   there; a closing result is then loaded into the output register, which drives
//   m_tvalid until the receiver takes it.
// throughput: one input transfer per cycle unless stalled; each is decided in a
//   single pass of compare and mask logic on the event state registers.
// reset: synchronous, active low; clears the event state and both stages,
//   and loads the registers with 20000 and 200000 us.
// stall: a result waits in the output register; one more input transfer is
//   held in the input register, then s_tready drops until m_tready returns.
`timescale 1ns / 1ps
`include "beam_break_event_capture_defines.svh"
module beam_break_event_capture (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // channel [7:0], blocked [8], timestamp [72:9], zero pad [79:73]
    input  logic [bbec_pkg::S_DATA_W-1:0]    s_tdata,
    // op [0]
    input  logic                             s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // valid_res [0], timeout_flag [1], start_time [65:2], end_time [129:66],
    // seen_beams [145:130], low_beam [149:146], high_beam [153:150], zero pad
    output logic [bbec_pkg::M_DATA_W-1:0]    m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bbec_pkg::ADDR_W-1:0]      paddr,
    input  logic [bbec_pkg::CFG_W-1:0]       pwdata,
    output logic [bbec_pkg::CFG_W-1:0]       prdata,
    output logic                             pready
);
    import bbec_pkg::*;

    cfg_t    cfg;
    result_t core_res;
    result_t out_res;
    status_t status;
    logic    core_res_valid;
    logic    core_res_ready;

    // register file
    bbec_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register plus event state update
    bbec_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser),
        .in_channel   (s_tdata[CH_W-1:0]),
        .in_blocked   (s_tdata[CH_W]),
        .in_timestamp (s_tdata[CH_W+TS_W:CH_W+1]),
        .res_valid    (core_res_valid),
        .res_ready    (core_res_ready),
        .res          (core_res),
        .status       (status)
    );

    // result register toward the receiver
    bbec_oreg u_oreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack fields from the lowest bit up
    assign m_tdata = {
        {(M_DATA_W - $bits(result_t)){1'b0}},
        out_res.high_beam,
        out_res.low_beam,
        out_res.seen_beams,
        out_res.end_time,
        out_res.start_time,
        out_res.timeout_flag,
        out_res.valid_res
    };

    // no beam is held and none latched while no event is open
    `BBEC_ASSERT_IMPLY(a_idle_masks_clear, aclk, aresetn, !status.event_open,
        status.current_mask == '0 && status.seen_mask == '0,
        "masks set with no event open")
    // a beam currently blocked is always in the latched mask
    `BBEC_ASSERT_ALWAYS(a_current_in_seen, aclk, aresetn,
        (status.current_mask & ~status.seen_mask) == '0,
        "current mask not within latched mask")
    // a valid result has beams and ordered indexes
    `BBEC_ASSERT_IMPLY(a_valid_result_sane, aclk, aresetn, m_tvalid && out_res.valid_res,
        out_res.seen_beams != '0 && out_res.low_beam <= out_res.high_beam &&
        out_res.seen_beams[out_res.low_beam] && out_res.seen_beams[out_res.high_beam],
        "valid result with bad mask or index")
    // an invalid result reports zero indexes
    `BBEC_ASSERT_IMPLY(a_invalid_result_zero, aclk, aresetn, m_tvalid && !out_res.valid_res,
        out_res.low_beam == '0 && out_res.high_beam == '0,
        "invalid result with nonzero index")

endmodule

/* test/tb.sv */
// self-checking testbench for the beam break event capture block
`timescale 1ns / 1ps
module tb;
    import bbec_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    // settle margin after draining, on top of the input and output register path
    localparam int SETTLE_CYCLES = 8;
    localparam logic [63:0] TS_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // channel [7:0], blocked [8], timestamp [72:9], zero pad [79:73]
    logic [S_DATA_W-1:0] s_tdata = '0;
    // op [0]
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // valid_res [0], timeout_flag [1], start_time [65:2], end_time [129:66],
    // seen_beams [145:130], low_beam [149:146], high_beam [153:150], zero pad
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [CFG_W-1:0]    pwdata = '0;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    beam_break_event_capture DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predicted block state, mirrors the event tracker
    logic [CFG_W-1:0]  quiet_cfg;
    logic [CFG_W-1:0]  max_ev_cfg;
    logic              ev_open;
    logic [MASK_W-1:0] active_beams;
    logic [MASK_W-1:0] latched_beams;
    logic [TS_W-1:0]   ev_start;
    logic [TS_W-1:0]   last_edge_ts;

    // closed events predicted but not yet seen on the result stream
    result_t closed_events_q[$];

    int fail_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int quiet_closes = 0;
    int timeout_closes = 0;
    int invalid_closes = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;
    logic [TS_W-1:0] stim_time = '0;

    function automatic logic past_limit_at(logic [TS_W-1:0] ts);
        return (ts >= ev_start) && ((ts - ev_start) > {32'd0, max_ev_cfg});
    endfunction

    // emit the expected result for the open event and drop back to idle
    function automatic void close_tracked_event(logic [TS_W-1:0] ts, logic by_timeout);
        result_t r;
        logic    found;
        r = '0;
        found = 1'b0;
        r.valid_res    = (latched_beams != '0) && (ts >= ev_start);
        r.timeout_flag = by_timeout;
        r.start_time   = ev_start;
        r.end_time     = ts;
        r.seen_beams   = latched_beams;
        if (r.valid_res) begin
            for (int i = 0; i < BEAM_COUNT; i++) begin
                if (latched_beams[i]) begin
                    if (!found) begin
                        r.low_beam = IDX_W'(i);
                    end
                    found = 1'b1;
                    r.high_beam = IDX_W'(i);
                end
            end
        end
        closed_events_q.push_back(r);
        ev_open       = 1'b0;
        active_beams  = '0;
        latched_beams = '0;
        ev_start      = '0;
        last_edge_ts  = '0;
    endfunction

    function automatic void track_beam_item(op_t op, logic [CH_W-1:0] ch, logic blk,
                                            logic [TS_W-1:0] ts);
        logic [MASK_W-1:0] bit_sel;
        if (op == OP_POLL) begin
            if (!ev_open) begin
                return;
            end
            if (past_limit_at(ts)) begin
                close_tracked_event(ts, 1'b1);
            end else if (active_beams == '0 && ts >= last_edge_ts &&
                         (ts - last_edge_ts) >= {32'd0, quiet_cfg}) begin
                close_tracked_event(ts, 1'b0);
            end
            return;
        end
        // out-of-range channels leave no trace
        if (ch >= BEAM_COUNT) begin
            return;
        end
        bit_sel = MASK_W'(1) << ch;
        if (ev_open && past_limit_at(ts)) begin
            close_tracked_event(ts, 1'b1);
            if (blk) begin
                ev_open       = 1'b1;
                ev_start      = ts;
                last_edge_ts  = ts;
                active_beams  = bit_sel;
                latched_beams = bit_sel;
            end
            return;
        end
        if (blk) begin
            if (!ev_open) begin
                ev_open       = 1'b1;
                ev_start      = ts;
                latched_beams = '0;
            end
            active_beams  = active_beams | bit_sel;
            latched_beams = latched_beams | bit_sel;
        end else if (ev_open) begin
            active_beams = active_beams & ~bit_sel;
        end
        last_edge_ts = ts;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result stream: random backpressure and field-by-field check
    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.valid_res    = m_tdata[0];
            got.timeout_flag = m_tdata[1];
            got.start_time   = m_tdata[65:2];
            got.end_time     = m_tdata[129:66];
            got.seen_beams   = m_tdata[145:130];
            got.low_beam     = m_tdata[149:146];
            got.high_beam    = m_tdata[153:150];
            if (closed_events_q.size() == 0) begin
                $error("result transfer with no event closed");
                fail_count++;
            end else begin
                want = closed_events_q.pop_front();
                compare_field("valid_res", 64'(want.valid_res), 64'(got.valid_res));
                compare_field("timeout_flag", 64'(want.timeout_flag), 64'(got.timeout_flag));
                compare_field("start_time", want.start_time, got.start_time);
                compare_field("end_time", want.end_time, got.end_time);
                compare_field("seen_beams", 64'(want.seen_beams), 64'(got.seen_beams));
                compare_field("low_beam", 64'(want.low_beam), 64'(got.low_beam));
                compare_field("high_beam", 64'(want.high_beam), 64'(got.high_beam));
                results_checked++;
                if (!want.valid_res) begin
                    invalid_closes++;
                end else if (want.timeout_flag) begin
                    timeout_closes++;
                end else begin
                    quiet_closes++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // any transfer or register access counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input transfer; returns at the edge where it was taken
    task automatic send_item(op_t op, logic [CH_W-1:0] ch, logic blk, logic [TS_W-1:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, ts, blk, ch};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        track_beam_item(op, ch, blk, ts);
        if (op == OP_POLL || ch < BEAM_COUNT) begin
            items_sent++;
        end
    endtask

    // hold off the sender until every closed event has been delivered
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (closed_events_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write followed by a readback of the same register
    task automatic write_register(reg_idx_t idx, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (idx == REG_QUIET_TIME) begin
            quiet_cfg = value;
        end else begin
            max_ev_cfg = value;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (prdata !== value) begin
            $error("prdata mismatch: expected %0h, got %0h", value, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_ignored_items();
        send_item(OP_POLL, 8'd0, 1'b0, 64'd100);     // poll with nothing open
        send_item(OP_EDGE, 8'd255, 1'b1, 64'd200);   // channel far out of range
        send_item(OP_EDGE, 8'd16, 1'b1, 64'd210);    // first channel past the array
        send_item(OP_EDGE, 8'd3, 1'b0, 64'd220);     // clear edge, no event open
        wait_drained();
    endtask

    task automatic test_quiet_close();
        send_item(OP_EDGE, 8'd0, 1'b1, 64'd1000);
        send_item(OP_EDGE, 8'd15, 1'b1, 64'd1010);
        send_item(OP_EDGE, 8'd16, 1'b0, 64'd1015);
        send_item(OP_EDGE, 8'd0, 1'b0, 64'd1020);
        send_item(OP_EDGE, 8'd15, 1'b0, 64'd1030);
        // one short of the quiet time, then exactly on it
        send_item(OP_POLL, 8'd0, 1'b0, 64'd1030 + quiet_cfg - 1);
        send_item(OP_POLL, 8'd0, 1'b0, 64'd1030 + quiet_cfg);
        wait_drained();
    endtask

    task automatic test_timeouts();
        // poll right at the limit stays open, one past it times out
        send_item(OP_EDGE, 8'd7, 1'b1, 64'd5000000);
        send_item(OP_POLL, 8'd0, 1'b0, 64'd5000000 + max_ev_cfg);
        send_item(OP_POLL, 8'd0, 1'b0, 64'd5000000 + max_ev_cfg + 1);
        // late blocked edge closes the old event and opens a new one
        send_item(OP_EDGE, 8'd4, 1'b1, 64'd6000000);
        send_item(OP_EDGE, 8'd9, 1'b1, 64'd6000000 + max_ev_cfg + 1);
        wait_drained();
    endtask

    task automatic test_time_reversal();
        // event from the previous test is still open on channel 9
        send_item(OP_POLL, 8'd0, 1'b0, 64'd100);
        send_item(OP_EDGE, 8'd9, 1'b0, 64'd300);
        // quiet close that ends before the start: reported as not valid
        send_item(OP_POLL, 8'd0, 1'b0, 64'd300 + quiet_cfg);
        wait_drained();
    endtask

    task automatic test_timestamp_extremes();
        send_item(OP_EDGE, 8'd1, 1'b1, TS_MAX - 15);
        send_item(OP_EDGE, 8'd1, 1'b0, TS_MAX);
        send_item(OP_POLL, 8'd0, 1'b0, TS_MAX);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_register(REG_QUIET_TIME, 32'd0);
        write_register(REG_MAX_EVENT, 32'd0);
        send_item(OP_POLL, 8'd0, 1'b0, 64'd0);
        send_item(OP_EDGE, 8'd6, 1'b1, TS_MAX);
        send_item(OP_EDGE, 8'd6, 1'b0, TS_MAX);
        send_item(OP_POLL, 8'd0, 1'b0, TS_MAX);
        wait_drained();
        write_register(REG_QUIET_TIME, 32'hFFFF_FFFF);
        write_register(REG_MAX_EVENT, 32'hFFFF_FFFF);
    endtask

    // well-formed burst: a few beams break, clear again, then polls around quiet
    task automatic send_beam_burst();
        int              nbeams;
        logic [CH_W-1:0] chs[4];
        nbeams = $urandom_range(1, 4);
        for (int i = 0; i < nbeams; i++) begin
            chs[i] = CH_W'($urandom_range(0, BEAM_COUNT - 1));
            stim_time += $urandom_range(0, 12);
            send_item(OP_EDGE, chs[i], 1'b1, stim_time);
        end
        if ($urandom_range(1) == 1) begin
            stim_time += $urandom_range(0, 30);
            send_item(OP_POLL, CH_W'($urandom), 1'($urandom), stim_time);
        end
        for (int i = 0; i < nbeams; i++) begin
            stim_time += $urandom_range(0, 12);
            send_item(OP_EDGE, chs[i], 1'b0, stim_time);
        end
        if ($urandom_range(2) == 0) begin
            send_item(OP_POLL, 8'd0, 1'b0, stim_time + quiet_cfg - 1);
        end
        stim_time += quiet_cfg + $urandom_range(0, 3);
        send_item(OP_POLL, CH_W'($urandom), 1'($urandom), stim_time);
    endtask

    // unstructured traffic: random edges, polls, bad channels, time jumps
    task automatic send_noise_item();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) begin
            stim_time += $urandom_range(0, 60);
            send_item(OP_EDGE, CH_W'($urandom_range(0, BEAM_COUNT - 1)), 1'($urandom),
                      stim_time);
        end else if (sel < 75) begin
            stim_time += $urandom_range(0, 80);
            send_item(OP_POLL, CH_W'($urandom), 1'($urandom), stim_time);
        end else if (sel < 85) begin
            send_item(OP_EDGE, CH_W'($urandom_range(BEAM_COUNT, 255)), 1'($urandom),
                      stim_time);
        end else if (sel < 93) begin
            // time running backwards without moving the stimulus clock
            send_item(op_t'($urandom_range(1)), CH_W'($urandom_range(0, BEAM_COUNT - 1)),
                      1'($urandom), stim_time - $urandom_range(0, 100));
        end else begin
            stim_time = {$urandom, $urandom};
            send_item(op_t'($urandom_range(1)), CH_W'($urandom), 1'($urandom), stim_time);
        end
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, logic [CFG_W-1:0] quiet,
                                       logic [CFG_W-1:0] max_ev, int item_count);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_register(REG_QUIET_TIME, quiet);
        write_register(REG_MAX_EVENT, max_ev);
        stop_at = items_sent + item_count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 65) begin
                send_beam_burst();
            end else begin
                repeat ($urandom_range(1, 6)) send_noise_item();
            end
            if ($urandom_range(99) < 3) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        quiet_cfg     = 32'd20000;
        max_ev_cfg    = 32'd200000;
        ev_open       = 1'b0;
        active_beams  = '0;
        latched_beams = '0;
        ev_start      = '0;
        last_edge_ts  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ignored_items();
        test_quiet_close();
        test_timeouts();
        test_time_reversal();
        test_timestamp_extremes();
        test_register_extremes();
        test_random_traffic(15, 67, 32'd25, 32'd300, 360);
        test_random_traffic(67, 15, 32'd0, 32'd0, 360);
        test_random_traffic(0, 0, 32'($urandom_range(1, 100)), 32'hFFFF_FFFF, 360);

        $display("summary: %0d input items, %0d events checked (%0d quiet, %0d timed out,",
                 items_sent, results_checked, quiet_closes, timeout_closes);
        $display("summary: %0d reported invalid), register extremes and time wrap covered",
                 invalid_closes);
        if (fail_count == 0 && closed_events_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
